[src/md5md_pkg.sv]
// Shared constants, control struct and round functions for the MD5 digest block.
package md5md_pkg;

	localparam int unsigned BUF_WORDS = 16;
	localparam int unsigned BUF_AW    = 4;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS    = 6'h3F;
	localparam logic [6:0] LAST_CNT    = 7'd64;
	localparam logic [3:0] LEN_LO_WORD = 4'd14;
	localparam logic [3:0] LEN_HI_WORD = 4'd15;
	localparam logic [1:0] LAST_IDX    = 2'd3;

	localparam logic [31:0] RND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	typedef struct packed {
		logic       init;
		logic       start;
		logic       step;
		logic       fin;
		logic [5:0] rnd;
	} md5md_ctl_t;

	// message word used by round i
	function automatic logic [3:0] msg_idx(input logic [5:0] i);
		logic [3:0] n;
		logic [3:0] g;
		n = i[3:0];
		case (i[5:4])
			2'd0: g = n;
			2'd1: g = n + {n[1:0], 2'b00} + 4'd1;
			2'd2: g = n + {n[2:0], 1'b0} + 4'd5;
			2'd3: g = {n[0], 3'b000} - n;
			default: g = n;
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		return (v << s) | (v >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

[src/md5md_ram.sv]
// Generic single-port-write, registered-read RAM.
module md5md_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/md5md_core.sv]
// MD5 round unit: working variables, one round per cycle, and the chaining words.
module md5md_core
	import md5md_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  md5md_ctl_t       ctl,
	input  logic [31:0]      msg_word,
	output logic [3:0][31:0] chain
);

	logic [3:0][31:0] chain_q;
	logic [31:0]      a_q, b_q, c_q, d_q;
	logic [31:0]      f;
	logic [31:0]      t;
	logic [31:0]      b_new;

	always_comb begin
		case (ctl.rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		t     = a_q + f + RND_K[ctl.rnd] + msg_word;
		b_new = b_q + rotl32(t, rot_amt({ctl.rnd[5:4], ctl.rnd[1:0]}));
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctl.step) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {IV3, IV2, IV1, IV0};
		end else if (ctl.init) begin
			chain_q <= {IV3, IV2, IV1, IV0};
		end else if (ctl.fin) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	assign chain = chain_q;

endmodule

[src/md5_message_digest_top.sv]
// MD5 digest top level: byte gathering, padding sequencer, buffer RAM and digest output.
//
//   channel | signals                                     | transfer when
//   --------+---------------------------------------------+-------------------------
//   input   | data_byte, byte_present, last_byte          | in_valid && !in_stall
//   output  | digest_word, word_index, last_word          | out_valid && !out_stall
//
// An ordinary byte is gathered into the current word. A byte that fills the 64-byte block
// starts a compression: the working words are loaded, 64 rounds run against the buffer RAM's
// read port, then the result is added into the chaining words. A final item adds one write
// per padded word, one or two compressions, then four digest transfers. Reset is
// immediate; the buffer RAM needs no clearing pass. in_stall is high for the whole of
// that work; out_stall holds the current digest word.
module md5_message_digest_top
	import md5md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [6:0]       cnt_q;
	logic [5:0]       pos_q;
	logic [31:0]      word_q;
	logic [63:0]      bit_count_q;
	logic [5:0]       pad_p_q;
	logic [3:0]       wi_q;
	logic             first_q;
	logic             final_q;
	logic             padding_q;
	logic             pend_last_q;
	logic [1:0]       idx_q;

	logic              in_fire;
	logic              out_fire;
	logic [31:0]       merged;
	logic [31:0]       partial;
	logic [31:0]       pad_word;
	logic [5:0]        pos_inc;
	logic              ram_we;
	logic [BUF_AW-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [BUF_AW-1:0] ram_raddr;
	logic [31:0]       ram_rdata;
	md5md_ctl_t        ctl;
	logic [3:0][31:0]  chain;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign pos_inc  = pos_q + 6'd1;

	always_comb begin
		merged = word_q;
		merged[{pos_q[1:0], 3'b000} +: 8] = data_byte;
	end

	// lanes below the pad position keep message bytes, then the pad byte, then zeros
	always_comb begin
		for (int lane = 0; lane < 4; lane++) begin
			if (2'(lane) < pad_p_q[1:0]) begin
				partial[lane*8 +: 8] = word_q[lane*8 +: 8];
			end else if (2'(lane) == pad_p_q[1:0]) begin
				partial[lane*8 +: 8] = PAD_BYTE;
			end else begin
				partial[lane*8 +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		if (first_q && wi_q == pad_p_q[5:2]) begin
			pad_word = partial;
		end else if (final_q && wi_q == LEN_LO_WORD) begin
			pad_word = bit_count_q[31:0];
		end else if (final_q && wi_q == LEN_HI_WORD) begin
			pad_word = bit_count_q[63:32];
		end else begin
			pad_word = 32'h0;
		end
	end

	// writes and reads of the buffer fall in different states, so no forwarding is needed
	always_comb begin
		if (state_q == ST_PAD) begin
			ram_we    = 1'b1;
			ram_waddr = wi_q;
			ram_wdata = pad_word;
		end else begin
			ram_we    = in_fire && byte_present && (pos_q[1:0] == 2'b11);
			ram_waddr = pos_q[5:2];
			ram_wdata = merged;
		end
	end

	assign ram_re    = (state_q == ST_COMP) && (cnt_q != LAST_CNT);
	assign ram_raddr = msg_idx(cnt_q[5:0]);

	always_comb begin
		ctl.init  = (state_q == ST_OUT) && !out_stall && (idx_q == LAST_IDX);
		ctl.start = (state_q == ST_COMP) && (cnt_q == 7'd0);
		ctl.step  = (state_q == ST_COMP) && (cnt_q != 7'd0);
		ctl.fin   = (state_q == ST_FIN);
		ctl.rnd   = cnt_q[5:0] - 6'd1;
	end

	md5md_ram #(
		.WIDTH(32),
		.DEPTH(BUF_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	md5md_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.msg_word(ram_rdata),
		.chain   (chain)
	);

	always_ff @(posedge clk) begin
		if (in_fire && byte_present) begin
			word_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 7'd0;
			pos_q       <= 6'd0;
			bit_count_q <= 64'd0;
			pad_p_q     <= 6'd0;
			wi_q        <= 4'd0;
			first_q     <= 1'b0;
			final_q     <= 1'b0;
			padding_q   <= 1'b0;
			pend_last_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (byte_present) begin
							bit_count_q <= bit_count_q + 64'd8;
							pos_q       <= pos_inc;
						end
						if (byte_present && pos_q == LAST_POS) begin
							state_q     <= ST_COMP;
							cnt_q       <= 7'd0;
							padding_q   <= 1'b0;
							pend_last_q <= last_byte;
						end else if (last_byte) begin
							state_q   <= ST_PAD;
							pad_p_q   <= byte_present ? pos_inc : pos_q;
							wi_q      <= byte_present ? pos_inc[5:2] : pos_q[5:2];
							first_q   <= 1'b1;
							final_q   <= byte_present ? (pos_inc < PAD_LEN_POS)
							                          : (pos_q < PAD_LEN_POS);
							padding_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (wi_q == LEN_HI_WORD) begin
						state_q <= ST_COMP;
						cnt_q   <= 7'd0;
					end else begin
						wi_q <= wi_q + 4'd1;
					end
				end
				ST_COMP: begin
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_FIN: begin
					if (padding_q && final_q) begin
						state_q <= ST_OUT;
						idx_q   <= 2'd0;
					end else if (padding_q) begin
						// length did not fit: run a second padded block
						state_q <= ST_PAD;
						wi_q    <= 4'd0;
						first_q <= 1'b0;
						final_q <= 1'b1;
					end else if (pend_last_q) begin
						state_q     <= ST_PAD;
						pad_p_q     <= 6'd0;
						wi_q        <= 4'd0;
						first_q     <= 1'b1;
						final_q     <= 1'b1;
						padding_q   <= 1'b1;
						pend_last_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (idx_q == LAST_IDX) begin
							state_q     <= ST_IDLE;
							idx_q       <= 2'd0;
							pos_q       <= 6'd0;
							bit_count_q <= 64'd0;
							padding_q   <= 1'b0;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = chain[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_IDX);

	a_no_write_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP || state_q == ST_FIN) |-> !ram_we)
		else $error("buffer written during compression");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (cnt_q <= LAST_CNT))
		else $error("round counter out of range");

	a_block_full_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && byte_present && pos_q == LAST_POS) |=> (state_q == ST_COMP && cnt_q == 7'd0))
		else $error("full block did not start compression");

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_word) |=> (pos_q == 6'd0 && bit_count_q == 64'd0 && state_q == ST_IDLE))
		else $error("state not reinitialised after digest");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the MD5 digest block: byte stream in, four digest words out.
module testbench;

	localparam int HALF_HI      = 6;
	localparam int HALF_LO      = 6;
	localparam int RESET_CYCLES = 7;
	localparam int ITEM_TARGET  = 430;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int TIMEOUT_NS   = 8_000_000;

	// per-step left rotations, four per round, step 0 in the low bits
	localparam logic [79:0] ROT_TAB = {
		5'd21, 5'd15, 5'd10, 5'd6, 5'd23, 5'd16, 5'd11, 5'd4,
		5'd20, 5'd14, 5'd9, 5'd5, 5'd22, 5'd17, 5'd12, 5'd7
	};

	// well-known digests, written as the usual hex string
	localparam logic [127:0] MD5_EMPTY = 128'hd41d8cd98f00b204e9800998ecf8427e;
	localparam logic [127:0] MD5_A     = 128'h0cc175b9c0f1b6a831c399e269772661;
	localparam logic [127:0] MD5_ABC   = 128'h900150983cd24fb0d6963f7d28e17f72;

	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         last;
		logic         typed;
		logic [127:0] digest;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        tail;
	} digest_word_t;

	localparam int DIR_N = 14;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, MD5_EMPTY},   // empty message straight after reset
		'{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, MD5_ABC},     // byte on the final transfer
		'{8'ha5, 1'b0, 1'b0, 1'b0, 128'h0},      // empty item, ignored
		'{8'h00, 1'b0, 1'b1, 1'b1, MD5_EMPTY},   // state back at its initial values
		'{8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h5a, 1'b0, 1'b0, 1'b0, 128'h0},      // empty item mid-message
		'{8'h80, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h7f, 1'b0, 1'b1, 1'b0, 128'h0},      // empty final after bytes
		'{8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
		'{8'h61, 1'b1, 1'b1, 1'b1, MD5_A}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	// message state of the predictor
	logic [31:0] msg_chain [4];
	logic [31:0] msg_buf [16];
	logic [63:0] msg_bits;
	logic [5:0]  msg_pos;
	logic [31:0] sine_add [64];

	digest_word_t pending_words [$];
	int err_count = 0;
	int tx_idle_pct = 38;
	int rx_idle_pct = 78;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_cnt = 0;

	md5_message_digest_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always begin
		#HALF_LO clk = 1'b1;
		#HALF_HI clk = 1'b0;
	end

	function automatic void restart_message();
		msg_chain[0] = 32'h67452301;
		msg_chain[1] = 32'hefcdab89;
		msg_chain[2] = 32'h98badcfe;
		msg_chain[3] = 32'h10325476;
		msg_bits = '0;
		msg_pos = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, t;
		int g, s;
		a = msg_chain[0];
		b = msg_chain[1];
		c = msg_chain[2];
		d = msg_chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = 5 * i + 1;
				end
				2: begin
					f = b ^ c ^ d;
					g = 3 * i + 5;
				end
				default: begin
					f = c ^ (b | ~d);
					g = 7 * i;
				end
			endcase
			t = a + f + sine_add[i] + msg_buf[g % 16];
			s = ROT_TAB[5 * ((i / 16) * 4 + i % 4) +: 5];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		msg_chain[0] += a;
		msg_chain[1] += b;
		msg_chain[2] += c;
		msg_chain[3] += d;
	endfunction

	function automatic void put_byte(input int pos, input logic [7:0] v);
		msg_buf[pos / 4][(pos % 4) * 8 +: 8] = v;
	endfunction

	// advance the message state by one transfer and queue any digest it completes
	function automatic void absorb_item(input stim_row_t it);
		int p;
		logic [31:0] w;
		if (it.present) begin
			put_byte(msg_pos, it.data);
			msg_bits += 64'd8;
			msg_pos = msg_pos + 6'd1;
			if (msg_pos == 6'd0)
				compress_block();
		end
		if (!it.last)
			return;
		p = msg_pos;
		put_byte(p, 8'h80);
		for (int k = p + 1; k < 64; k++)
			put_byte(k, 8'h00);
		// no room left for the length: it takes a block of its own
		if (p >= 56) begin
			compress_block();
			foreach (msg_buf[k])
				msg_buf[k] = '0;
		end
		msg_buf[14] = msg_bits[31:0];
		msg_buf[15] = msg_bits[63:32];
		compress_block();
		for (int k = 0; k < 4; k++) begin
			w = msg_chain[k];
			if (it.typed)
				for (int j = 0; j < 4; j++)
					w[8 * j +: 8] = it.digest[127 - 8 * (4 * k + j) -: 8];
			pending_words.push_back('{word: w, idx: 2'(k), tail: (k == 3)});
		end
		restart_message();
	endfunction

	function automatic stim_row_t rand_row(input logic present, input logic last);
		stim_row_t r;
		r.data = 8'($urandom_range(255));
		r.present = present;
		r.last = last;
		r.typed = 1'b0;
		r.digest = '0;
		return r;
	endfunction

	task automatic send_item(input stim_row_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom_range(255));
			byte_present <= 1'($urandom_range(1));
			last_byte <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= it.data;
		byte_present <= it.present;
		last_byte <= it.last;
		do
			@(posedge clk);
		while (in_stall);
		absorb_item(it);
	endtask

	// receiver: random stall, or one long hold-off when asked
	always @(posedge clk) begin
		if (hold_done != hold_asked) begin
			if (hold_cnt == LONG_HOLD - 1) begin
				hold_cnt <= 0;
				hold_done <= hold_done + 1;
				out_stall <= 1'b0;
			end else begin
				hold_cnt <= hold_cnt + 1;
				out_stall <= 1'b1;
			end
		end else
			out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin : digest_check
		digest_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("digest_word: unexpected transfer, got %h", digest_word);
				err_count++;
			end else begin
				e = pending_words.pop_front();
				if (digest_word !== e.word) begin
					$error("digest_word: expected %h, got %h", e.word, digest_word);
					err_count++;
				end
				if (word_index !== e.idx) begin
					$error("word_index: expected %0d, got %0d", e.idx, word_index);
					err_count++;
				end
				if (last_word !== e.tail) begin
					$error("last_word: expected %b, got %b", e.tail, last_word);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		real x;
		int sent, len, phase;
		logic byte_final;
		for (int i = 0; i < 64; i++) begin
			x = $sin(i + 1.0);
			if (x < 0.0)
				x = -x;
			sine_add[i] = 32'(longint'(x * 4294967296.0 - 0.5));
		end
		restart_message();
		foreach (msg_buf[k])
			msg_buf[k] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_item(DIR_ROWS[i]);

		sent = 0;
		phase = 0;
		while (sent < ITEM_TARGET) begin
			if (phase == 0 && sent >= ITEM_TARGET / 3) begin
				phase = 1;
				tx_idle_pct = 78;
				rx_idle_pct <= 38;
			end else if (phase == 1 && sent >= 2 * ITEM_TARGET / 3) begin
				phase = 2;
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
				hold_asked <= hold_asked + 1;
			end
			// favour lengths either side of the length slot and the block boundary
			case ($urandom_range(9))
				0, 1, 2, 3: len = $urandom_range(12);
				4: len = 55 + $urandom_range(2);
				5: len = 63 + $urandom_range(2);
				6: begin
					case ($urandom_range(3))
						0: len = 119;
						1: len = 120;
						2: len = 127;
						default: len = 128;
					endcase
				end
				default: len = $urandom_range(40);
			endcase
			if (len > ITEM_TARGET - sent)
				len = ITEM_TARGET - sent;
			byte_final = (len > 0) && ($urandom_range(1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) begin
					send_item(rand_row(1'b0, 1'b0));
					sent++;
				end
				send_item(rand_row(1'b1, byte_final && (i == len - 1)));
				sent++;
			end
			if (!byte_final) begin
				send_item(rand_row(1'b0, 1'b1));
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
